>>> rtl/core/r10nv_pkg.sv
`timescale 1ns / 1ps
package r10nv_pkg;

    localparam int PIX_W      = 8;
    localparam int LINE_ROWS  = 4;
    localparam int SLOT_W     = $clog2(LINE_ROWS);
    localparam int ROW_WORD_W = LINE_ROWS * PIX_W;
    localparam int POS_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 14;
    localparam int BYTE_CNT_W = 13;
    localparam int PIX_CNT_W  = 13;
    localparam logic [BYTE_CNT_W-1:0] BYTE_LAST = 13'd8191;
    localparam logic [2:0] GROUP_LSB = 3'd4;

    localparam int CU_R = -43;
    localparam int CU_G = -85;
    localparam int CU_B = 128;
    localparam int CV_R = 128;
    localparam int CV_G = -107;
    localparam int CV_B = -21;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_ROW_STRIDE = 3'd1,
        CFG_CROP_LEFT  = 3'd2,
        CFG_CROP_TOP   = 3'd3,
        CFG_OUT_WIDTH  = 3'd4,
        CFG_OUT_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             done;
    } t_meta;

    typedef struct packed {
        t_meta             meta;
        logic [SLOT_W-1:0] slot;
        logic [PIX_W-1:0]  pix;
    } t_tap;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
    } t_rgb;

    function automatic logic [PIX_W-1:0] pick(input logic [ROW_WORD_W-1:0] w,
                                              input logic [SLOT_W-1:0] s);
        return w[s*PIX_W +: PIX_W];
    endfunction

    function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        logic [PIX_W:0] s;
        s = {1'b0, a} + {1'b0, b} + 1'b1;
        return s[PIX_W:1];
    endfunction

    function automatic logic [PIX_W-1:0] avg4(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b,
                                              input logic [PIX_W-1:0] c,
                                              input logic [PIX_W-1:0] d);
        logic [PIX_W+1:0] s;
        s = 10'(a) + 10'(b) + 10'(c) + 10'(d) + 10'd2;
        return s[PIX_W+1:2];
    endfunction

    function automatic logic [PIX_W-1:0] luma(input t_rgb p);
        logic [16:0] s;
        s = 17'd77 * 17'(p.r) + 17'd150 * 17'(p.g) + 17'd29 * 17'(p.b) + 17'd128;
        return s[15:8];
    endfunction

    function automatic logic [PIX_W-1:0] chroma(input t_rgb p, input int kr,
                                                input int kg, input int kb);
        logic signed [17:0] s;
        logic signed [17:0] t;
        s = $signed(18'(kr)) * $signed(18'(p.r)) + $signed(18'(kg)) * $signed(18'(p.g))
            + $signed(18'(kb)) * $signed(18'(p.b)) + 18'sd128;
        t = (s >>> 8) + 18'sd128;
        if (t < 18'sd0) begin
            return '0;
        end else if (t > 18'sd255) begin
            return '1;
        end
        return t[PIX_W-1:0];
    endfunction

endpackage

>>> rtl/core/r10nv_ram.sv
`timescale 1ns / 1ps
module r10nv_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 4096,
    parameter int LANES  = 4
) (
    input  logic                     i_clk,
    input  logic [LANES-1:0]         i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [DATA_W-1:0]        o_rdata_a,
    output logic [DATA_W-1:0]        o_rdata_b
);
    localparam int LANE_W = DATA_W / LANES;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            if (i_we[l]) begin
                r_mem[i_waddr][l*LANE_W +: LANE_W] <= i_wdata[l*LANE_W +: LANE_W];
            end
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;
endmodule

>>> rtl/core/raw10_bayer_to_nv12_tiles.sv
`timescale 1ns / 1ps
// Packed RAW10 bytes go in at one byte per cycle while o_in_stall is low, whatever the crop;
// the line store is one RAM of MAX_WIDTH entries, each holding one pixel of all four row
// slots in byte lanes, written one lane per kept pixel and read at columns x-1 and x+1 on
// the same edge, so every kept pixel costs a single store access. A tile passes through
// the window, demosaic, luma and chroma registers in turn after the edge that takes the
// byte completing it. Input stalls only when four finished or part-finished tiles sit
// behind a stalled output. The store has no reset or clearing pass; the halo columns
// outside the source read whatever an earlier row left.
module raw10_bayer_to_nv12_tiles #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [7:0]                           i_raw_byte,
    input  logic                                 i_frame_start,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [11:0]                          o_tile_column,
    output logic [11:0]                          o_tile_row,
    output logic [7:0]                           o_luma_top_left,
    output logic [7:0]                           o_luma_top_right,
    output logic [7:0]                           o_luma_bottom_left,
    output logic [7:0]                           o_luma_bottom_right,
    output logic [7:0]                           o_chroma_blue,
    output logic [7:0]                           o_chroma_red,
    output logic                                 o_frame_done,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [r10nv_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [r10nv_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import r10nv_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam logic [CW-1:0] COL_LAST = CW'(MAX_WIDTH - 1);

    // configuration
    logic [12:0] r_source_width;
    logic [13:0] r_row_stride;
    logic [11:0] r_crop_left;
    logic [11:0] r_crop_top;
    logic [12:0] r_output_width;
    logic [12:0] r_output_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width  <= 13'd4076;
            r_row_stride    <= 14'd5104;
            r_crop_left     <= 12'd118;
            r_crop_top      <= 12'd322;
            r_output_width  <= 13'd3840;
            r_output_height <= 13'd2160;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_source_width  <= i_cfg_data[12:0];
                CFG_ROW_STRIDE: r_row_stride    <= i_cfg_data[13:0];
                CFG_CROP_LEFT:  r_crop_left     <= i_cfg_data[11:0];
                CFG_CROP_TOP:   r_crop_top      <= i_cfg_data[11:0];
                CFG_OUT_WIDTH:  r_output_width  <= i_cfg_data[12:0];
                CFG_OUT_HEIGHT: r_output_height <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // pipeline flow
    logic r_v0, r_v1, r_v2, r_ov;
    logic rdy_o, rdy2, rdy1, rdy0;
    logic accept;

    assign rdy_o      = !r_ov || !i_out_stall;
    assign rdy1       = !r_v1 || rdy2;
    assign rdy0       = !r_v0 || rdy1;
    assign o_in_stall = !rdy0;
    assign accept     = i_in_valid && rdy0;

    // byte and pixel counters
    logic [BYTE_CNT_W-1:0] r_byte_in_row, n_byte_in_row, b_cur;
    logic [2:0]            r_grp_pos, n_grp_pos, pos_cur;
    logic [PIX_CNT_W-1:0]  r_pix_col, n_pix_col, x_cur;
    logic [RW-1:0]         r_source_row, n_source_row, row_cur;
    logic                  row_end;

    assign b_cur   = i_frame_start ? '0 : r_byte_in_row;
    assign pos_cur = i_frame_start ? '0 : r_grp_pos;
    assign x_cur   = i_frame_start ? '0 : r_pix_col;
    assign row_cur = i_frame_start ? '0 : r_source_row;
    assign row_end = (15'(b_cur) + 15'd1 >= 15'(r_row_stride)) || (b_cur == BYTE_LAST);

    always_comb begin
        if (row_end) begin
            n_byte_in_row = '0;
            n_grp_pos     = '0;
            n_pix_col     = '0;
            n_source_row  = (32'(row_cur) + 1 >= MAX_HEIGHT) ? '0 : row_cur + 1'b1;
        end else begin
            n_byte_in_row = b_cur + 1'b1;
            n_grp_pos     = (pos_cur == GROUP_LSB) ? '0 : pos_cur + 1'b1;
            n_pix_col     = (pos_cur == GROUP_LSB) ? x_cur : x_cur + 1'b1;
            n_source_row  = row_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_in_row <= '0;
            r_grp_pos     <= '0;
            r_pix_col     <= '0;
            r_source_row  <= '0;
        end else if (accept) begin
            r_byte_in_row <= n_byte_in_row;
            r_grp_pos     <= n_grp_pos;
            r_pix_col     <= n_pix_col;
            r_source_row  <= n_source_row;
        end
    end

    // tile trigger: pixel at row crop_top+2+dy, column crop_left+1+dx
    logic               keep, trig, done;
    logic signed [15:0] dx, dy;
    logic [CW-1:0]      col, col_p1, col_m1;
    logic [SLOT_W-1:0]  slot;

    assign keep = (pos_cur != GROUP_LSB) && (x_cur < r_source_width)
                  && (32'(x_cur) < MAX_WIDTH);
    assign dy   = $signed(16'(row_cur)) - $signed(16'(r_crop_top)) - 16'sd2;
    assign dx   = $signed(16'(x_cur)) - $signed(16'(r_crop_left)) - 16'sd1;
    assign trig = keep && !dy[15] && !dy[0] && (dy < $signed(16'(r_output_height)))
                  && !dx[15] && !dx[0] && (dx < $signed(16'(r_output_width)));
    assign done = (dx + 16'sd2 >= $signed(16'(r_output_width)))
                  && (dy + 16'sd2 >= $signed(16'(r_output_height)));
    assign col    = x_cur[CW-1:0];
    assign col_p1 = (col == COL_LAST) ? '0 : col + 1'b1;
    assign col_m1 = (col == '0) ? COL_LAST : col - 1'b1;
    assign slot   = row_cur[SLOT_W-1:0];

    // line store, one byte lane per row slot
    logic [LINE_ROWS-1:0]  ram_we;
    logic                  ram_re;
    logic [ROW_WORD_W-1:0] rd_a, rd_b;
    logic [ROW_WORD_W-1:0] r_hist_a, r_hist_b;

    assign ram_re = accept && keep;
    assign ram_we = ram_re ? (LINE_ROWS'(1) << slot) : '0;

    r10nv_ram #(
        .DATA_W (ROW_WORD_W),
        .DEPTH  (MAX_WIDTH),
        .LANES  (LINE_ROWS)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (col),
        .i_wdata   ({LINE_ROWS{i_raw_byte}}),
        .i_re      (ram_re),
        .i_raddr_a (col_p1),
        .i_raddr_b (col_m1),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // previous pixel's reads give columns x and x-2
    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_hist_a <= rd_a;
            r_hist_b <= rd_b;
        end
    end

    t_tap r_p0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (rdy0) begin
            r_v0 <= accept && trig;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p0.meta.col  <= dx[POS_W-1:0];
            r_p0.meta.row  <= dy[POS_W-1:0];
            r_p0.meta.done <= done;
            r_p0.slot      <= slot;
            r_p0.pix       <= i_raw_byte;
        end
    end

    // window and demosaic
    logic [SLOT_W-1:0] s1, s2, s3;
    logic [PIX_W-1:0]  m0, m1, m2, em, e0, e1, e2, pm, p0, p1, p2, qm, q0, q1;
    t_rgb              px [4];

    assign s1 = r_p0.slot - SLOT_W'(1);
    assign s2 = r_p0.slot - SLOT_W'(2);
    assign s3 = r_p0.slot - SLOT_W'(3);

    always_comb begin
        m0 = pick(rd_b, s3);
        m1 = pick(r_hist_a, s3);
        m2 = pick(rd_a, s3);
        em = pick(r_hist_b, s2);
        e0 = pick(rd_b, s2);
        e1 = pick(r_hist_a, s2);
        e2 = pick(rd_a, s2);
        pm = pick(r_hist_b, s1);
        p0 = pick(rd_b, s1);
        p1 = pick(r_hist_a, s1);
        p2 = pick(rd_a, s1);
        qm = pick(r_hist_b, r_p0.slot);
        q0 = pick(rd_b, r_p0.slot);
        q1 = r_p0.pix;
        px[0] = '{r: avg2(em, e1), g: e0, b: avg2(m0, p0)};
        px[1] = '{r: e1, g: avg4(e0, e2, m1, p1), b: avg4(m0, m2, p0, p2)};
        px[2] = '{r: avg4(em, e1, qm, q1), g: avg4(pm, p1, e0, q0), b: p0};
        px[3] = '{r: avg2(e1, q1), g: p1, b: avg2(p0, p2)};
    end

    t_rgb  r_px [4];
    t_meta r_meta1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (rdy1) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_px    <= px;
            r_meta1 <= r_p0.meta;
        end
    end

    // luma and tile average
    t_rgb avg;

    always_comb begin
        avg.r = avg4(r_px[0].r, r_px[1].r, r_px[2].r, r_px[3].r);
        avg.g = avg4(r_px[0].g, r_px[1].g, r_px[2].g, r_px[3].g);
        avg.b = avg4(r_px[0].b, r_px[1].b, r_px[2].b, r_px[3].b);
    end

    logic [PIX_W-1:0] r_luma [4];
    t_rgb             r_avg;
    t_meta            r_meta2;

    assign rdy2 = !r_v2 || rdy_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            for (int i = 0; i < 4; i++) begin
                r_luma[i] <= luma(r_px[i]);
            end
            r_avg   <= avg;
            r_meta2 <= r_meta1;
        end
    end

    // chroma into the output register
    logic [PIX_W-1:0] r_out_luma [4];
    logic [PIX_W-1:0] r_out_cb, r_out_cr;
    t_meta            r_out_meta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (rdy_o) begin
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_o) begin
            r_out_luma <= r_luma;
            r_out_cb   <= chroma(r_avg, CU_R, CU_G, CU_B);
            r_out_cr   <= chroma(r_avg, CV_R, CV_G, CV_B);
            r_out_meta <= r_meta2;
        end
    end

    assign o_out_valid         = r_ov;
    assign o_tile_column       = r_out_meta.col;
    assign o_tile_row          = r_out_meta.row;
    assign o_luma_top_left     = r_out_luma[0];
    assign o_luma_top_right    = r_out_luma[1];
    assign o_luma_bottom_left  = r_out_luma[2];
    assign o_luma_bottom_right = r_out_luma[3];
    assign o_chroma_blue       = r_out_cb;
    assign o_chroma_red        = r_out_cr;
    assign o_frame_done        = r_out_meta.done;

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |-> (col_p1 != col) && (col_m1 != col))
        else $error("line store read and write hit the same column");

    a_stall_needs_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_v0 && r_v1 && r_v2 && r_ov)
        else $error("input stalled with room in the pipeline");

    a_window_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v0 && !rdy1 |=> r_v0 && $stable(r_p0) && $stable(rd_a) && $stable(r_hist_b))
        else $error("pending window lost while stalled");

    a_hist_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ram_re |=> $stable(r_hist_a) && $stable(r_hist_b))
        else $error("column history moved without a store read");
endmodule
